/* rtl/core/price_level_order_book_top_defines.svh */
// Assertion macros shared by the order book checker.
`ifndef PRICE_LEVEL_ORDER_BOOK_TOP_DEFINES_SVH
`define PRICE_LEVEL_ORDER_BOOK_TOP_DEFINES_SVH

// Implication checked in the same cycle, disabled during reset.
`define PLOB_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle, disabled during reset.
`define PLOB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/plob_pkg.sv */
// Package with the order book sizes, status codes and control structures.
`default_nettype none

package plob_pkg;

    localparam int LEVELS    = 64;
    localparam int USED_W    = $clog2(LEVELS + 1);
    localparam int PRICE_W   = 32;
    localparam int QTY_W     = 32;
    localparam int DEPTH_W   = 7;
    localparam int STATUS_W  = 2;

    localparam logic [STATUS_W-1:0] ST_INSERTED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_AGGREGATED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic compare;
        logic update;
        logic capture;
    } plob_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/plob_if.sv */
// Channel interfaces for orders in and book results out.
`default_nettype none

interface plob_order_if;
    logic        valid;
    logic        ready;
    logic        side_buy;
    logic [31:0] price;
    logic [31:0] quantity;

    modport source (output valid, output side_buy, output price, output quantity,
                    input ready);
    modport sink (input valid, input side_buy, input price, input quantity,
                  output ready);
endinterface

interface plob_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] high_bid;
    logic [31:0] low_ask;
    logic [31:0] spread;
    logic [6:0]  bid_depth;
    logic [6:0]  ask_depth;

    modport source (output valid, output status, output high_bid, output low_ask,
                    output spread, output bid_depth, output ask_depth, input ready);
    modport sink (input valid, input status, input high_bid, input low_ask,
                  input spread, input bid_depth, input ask_depth, output ready);
endinterface

`default_nettype wire

/* rtl/core/price_level_order_book_top.sv */
// Top level of the price-level order book.
// An order is latched at acceptance, all levels of its side are compared with
// it in parallel in the next cycle, the matching level is aggregated or the new
// level is shifted in during the cycle after (a new level on a full side is
// dropped), and the result is captured in the output step once the result
// register is free. The block takes the next order only after that capture, so
// it works on one order at a time; a result that is still waiting to be taken
// holds the following order in its capture step. Each side holds LEVELS price
// levels in a row of register cells; the level contents are undefined after
// reset, only the level counts are cleared.
`default_nettype none

module price_level_order_book_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    plob_order_if.sink  order_ch,
    plob_result_if.source result_ch
);
    import plob_pkg::*;

    plob_cmd_t cmd;

    // Sequencing.
    plob_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .ord_valid (order_ch.valid),
        .ord_ready (order_ch.ready),
        .res_valid (result_ch.valid),
        .res_ready (result_ch.ready),
        .cmd       (cmd)
    );

    // Level tables and result.
    plob_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .ord_side_buy (order_ch.side_buy),
        .ord_price    (order_ch.price),
        .ord_quantity (order_ch.quantity),
        .status       (result_ch.status),
        .high_bid     (result_ch.high_bid),
        .low_ask      (result_ch.low_ask),
        .spread       (result_ch.spread),
        .bid_depth    (result_ch.bid_depth),
        .ask_depth    (result_ch.ask_depth)
    );

endmodule

`default_nettype wire

/* rtl/core/plob_ctrl.sv */
// Controller that sequences one order through compare, update and result capture.
`default_nettype none

module plob_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               ord_valid,
    output logic                    ord_ready,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output plob_pkg::plob_cmd_t     cmd
);
    import plob_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // The result register is free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || res_ready;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !res_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (ord_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign ord_ready = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/core/plob_dp.sv */
// Datapath holding both sorted level tables, the per-level comparators and the result register.
`default_nettype none

module plob_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire plob_pkg::plob_cmd_t            cmd,
    input  wire logic                           ord_side_buy,
    input  wire logic [plob_pkg::PRICE_W-1:0]   ord_price,
    input  wire logic [plob_pkg::QTY_W-1:0]     ord_quantity,
    output logic [plob_pkg::STATUS_W-1:0]       status,
    output logic [plob_pkg::PRICE_W-1:0]        high_bid,
    output logic [plob_pkg::PRICE_W-1:0]        low_ask,
    output logic [plob_pkg::PRICE_W-1:0]        spread,
    output logic [plob_pkg::DEPTH_W-1:0]        bid_depth,
    output logic [plob_pkg::DEPTH_W-1:0]        ask_depth
);
    import plob_pkg::*;

    // Level tables, one register row of cells per side.
    logic [PRICE_W-1:0] bid_price_reg  [LEVELS];
    logic [QTY_W-1:0]   bid_total_reg  [LEVELS];
    logic [31:0]        bid_orders_reg [LEVELS];
    logic [PRICE_W-1:0] ask_price_reg  [LEVELS];
    logic [QTY_W-1:0]   ask_total_reg  [LEVELS];
    logic [31:0]        ask_orders_reg [LEVELS];
    logic [USED_W-1:0]  bid_used_reg, ask_used_reg;

    // Latched order and comparison results.
    logic               side_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [QTY_W-1:0]   qty_reg;
    logic [LEVELS-1:0]  match_reg, match_next;
    logic [LEVELS-1:0]  ins_reg, ins_next;
    logic [STATUS_W-1:0] st_reg, st_next;

    // Selected side views and next values.
    logic [PRICE_W-1:0] sel_price  [LEVELS];
    logic [QTY_W-1:0]   sel_total  [LEVELS];
    logic [31:0]        sel_orders [LEVELS];
    logic [USED_W-1:0]  sel_used;
    logic [PRICE_W-1:0] side_price_next  [LEVELS];
    logic [QTY_W-1:0]   side_total_next  [LEVELS];
    logic [31:0]        side_orders_next [LEVELS];
    logic [QTY_W-1:0]   hit_total;
    logic [31:0]        hit_orders;
    logic [QTY_W:0]     tot_sum;
    logic [32:0]        cnt_sum;
    logic [QTY_W-1:0]   tot_sat;
    logic [31:0]        cnt_sat;
    logic               agg, full, do_insert;

    // Result register.
    logic [STATUS_W-1:0] status_reg;
    logic [PRICE_W-1:0]  high_bid_reg, low_ask_reg, spread_reg;
    logic [DEPTH_W-1:0]  bid_depth_reg, ask_depth_reg;
    logic [PRICE_W-1:0]  bb_now, ba_now;

    // Select the table of the order's side.
    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            sel_price[i]  = side_reg ? bid_price_reg[i]  : ask_price_reg[i];
            sel_total[i]  = side_reg ? bid_total_reg[i]  : ask_total_reg[i];
            sel_orders[i] = side_reg ? bid_orders_reg[i] : ask_orders_reg[i];
        end
        sel_used = side_reg ? bid_used_reg : ask_used_reg;
    end

    // Every cell compares its price with the order at once. Since the table is
    // sorted, the cells that the new level goes in front of form a suffix.
    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            if (USED_W'(i) < sel_used)
            begin
                match_next[i] = (sel_price[i] == price_reg);
                ins_next[i]   = side_reg ? (price_reg > sel_price[i])
                                         : (price_reg < sel_price[i]);
            end
            else
            begin
                match_next[i] = 1'b0;
                ins_next[i]   = 1'b1;
            end
        end
    end

    // Gather the matching level and saturate its sums.
    always_comb
    begin
        hit_total  = '0;
        hit_orders = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            hit_total  = hit_total  | (match_reg[i] ? sel_total[i]  : '0);
            hit_orders = hit_orders | (match_reg[i] ? sel_orders[i] : '0);
        end
        tot_sum = {1'b0, hit_total} + {1'b0, qty_reg};
        cnt_sum = {1'b0, hit_orders} + 33'd1;
        tot_sat = tot_sum[QTY_W] ? '1 : tot_sum[QTY_W-1:0];
        cnt_sat = cnt_sum[32] ? '1 : cnt_sum[31:0];
    end

    assign agg       = |match_reg;
    assign full      = (sel_used == USED_W'(LEVELS));
    assign do_insert = !agg && !full;

    // Status of this order.
    always_comb
    begin
        if (agg)
            st_next = ST_AGGREGATED;
        else if (full)
            st_next = ST_DROPPED;
        else
            st_next = ST_INSERTED;
    end

    // Next contents of each cell: aggregate in place, or shift and insert.
    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            side_price_next[i]  = sel_price[i];
            side_total_next[i]  = sel_total[i];
            side_orders_next[i] = sel_orders[i];
            if (agg)
            begin
                if (match_reg[i])
                begin
                    side_total_next[i]  = tot_sat;
                    side_orders_next[i] = cnt_sat;
                end
            end
            else if (ins_reg[i])
            begin
                if (i == 0 || !ins_reg[(i == 0) ? 0 : i - 1])
                begin
                    side_price_next[i]  = price_reg;
                    side_total_next[i]  = qty_reg;
                    side_orders_next[i] = 32'd1;
                end
                else
                begin
                    side_price_next[i]  = sel_price[(i == 0) ? 0 : i - 1];
                    side_total_next[i]  = sel_total[(i == 0) ? 0 : i - 1];
                    side_orders_next[i] = sel_orders[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // Order latch and comparison registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            side_reg  <= ord_side_buy;
            price_reg <= ord_price;
            qty_reg   <= ord_quantity;
        end
        if (cmd.compare)
        begin
            match_reg <= match_next;
            ins_reg   <= ins_next;
        end
        if (cmd.update)
        begin
            st_reg <= st_next;
        end
    end

    // Level tables are written only on the order's side.
    always_ff @(posedge clk)
    begin
        if (cmd.update && (agg || do_insert))
        begin
            if (side_reg)
            begin
                bid_price_reg  <= side_price_next;
                bid_total_reg  <= side_total_next;
                bid_orders_reg <= side_orders_next;
            end
            else
            begin
                ask_price_reg  <= side_price_next;
                ask_total_reg  <= side_total_next;
                ask_orders_reg <= side_orders_next;
            end
        end
    end

    // Level counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bid_used_reg <= '0;
            ask_used_reg <= '0;
        end
        else if (cmd.update && do_insert)
        begin
            if (side_reg)
                bid_used_reg <= bid_used_reg + USED_W'(1);
            else
                ask_used_reg <= ask_used_reg + USED_W'(1);
        end
    end

    // Top of book after the update.
    assign bb_now = (bid_used_reg != '0) ? bid_price_reg[0] : '0;
    assign ba_now = (ask_used_reg != '0) ? ask_price_reg[0] : '0;

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            status_reg    <= st_reg;
            high_bid_reg  <= bb_now;
            low_ask_reg   <= ba_now;
            spread_reg    <= ba_now - bb_now;
            bid_depth_reg <= DEPTH_W'(bid_used_reg);
            ask_depth_reg <= DEPTH_W'(ask_used_reg);
        end
    end

    assign status    = status_reg;
    assign high_bid  = high_bid_reg;
    assign low_ask   = low_ask_reg;
    assign spread    = spread_reg;
    assign bid_depth = bid_depth_reg;
    assign ask_depth = ask_depth_reg;

endmodule

`default_nettype wire

/* rtl/core/plob_checker.sv */
// Port-level checker for the order book, bound to the top level.
`default_nettype none
`include "price_level_order_book_top_defines.svh"

module plob_port_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        ord_valid,
    input  wire logic        ord_ready,
    input  wire logic        res_valid,
    input  wire logic        res_ready,
    input  wire logic [1:0]  status,
    input  wire logic [31:0] high_bid,
    input  wire logic [31:0] low_ask,
    input  wire logic [31:0] spread
);
    import plob_pkg::*;

    // A result held back keeps its item.
    `PLOB_ASSERT_NEXT(a_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(status), "stalled result changed")

    // After an order is taken the block works on it before taking another.
    `PLOB_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, ord_valid && ord_ready, !ord_ready, "second order taken too early")

    // Status is one of the three defined codes.
    `PLOB_ASSERT_SAME(a_status, clk, rst_n, res_valid, status == ST_INSERTED || status == ST_AGGREGATED || status == ST_DROPPED, "undefined status")

    // The spread is the difference of the two best prices.
    `PLOB_ASSERT_SAME(a_spread, clk, rst_n, res_valid, spread == low_ask - high_bid, "spread mismatch")

endmodule

bind price_level_order_book_top plob_port_checker u_plob_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ord_valid (order_ch.valid),
    .ord_ready (order_ch.ready),
    .res_valid (result_ch.valid),
    .res_ready (result_ch.ready),
    .status    (result_ch.status),
    .high_bid  (result_ch.high_bid),
    .low_ask   (result_ch.low_ask),
    .spread    (result_ch.spread)
);

`default_nettype wire
